/* sv/gdw_pkg.sv */
`timescale 1ns / 1ps

package gdw_pkg;

	// default grid size
	localparam int MAX_ROWS_DEF = 16;
	localparam int MAX_COLS_DEF = 16;

	// fixed field widths
	localparam int COORD_W   = 4;
	localparam int CFG_W     = 5;
	localparam int REG_IDX_W = 1;
	localparam int DIR_W     = 3;

	// configuration register indexes
	localparam logic [REG_IDX_W-1:0] REG_ROWS = 1'd0;
	localparam logic [REG_IDX_W-1:0] REG_COLS = 1'd1;

	localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

	// item opcodes
	localparam logic OP_LOAD    = 1'b0;
	localparam logic OP_ADVANCE = 1'b1;

	// move order of the walk
	localparam logic [DIR_W-1:0] DIR_UP    = 3'd0;
	localparam logic [DIR_W-1:0] DIR_DOWN  = 3'd1;
	localparam logic [DIR_W-1:0] DIR_LEFT  = 3'd2;
	localparam logic [DIR_W-1:0] DIR_RIGHT = 3'd3;
	localparam logic [DIR_W-1:0] DIR_END   = 3'd4;

	// bit positions in a grid memory entry
	localparam int GRID_VISIT = 0;
	localparam int GRID_OPEN  = 1;
	localparam int GRID_W     = 2;

	typedef struct packed {
		logic               opcode;
		logic [COORD_W-1:0] cell_row;
		logic [COORD_W-1:0] cell_col;
		logic               cell_open;
	} item_t;

	typedef struct packed {
		logic [COORD_W-1:0] out_row;
		logic [COORD_W-1:0] out_col;
		logic               new_path;
		logic               done_res;
	} result_t;

	typedef struct packed {
		logic [REG_IDX_W-1:0] index;
		logic [CFG_W-1:0]     value;
	} cfg_wr_t;

endpackage

/* sv/gdw_chan_if.sv */
`timescale 1ns / 1ps

// valid/ready channel carrying one word of type T
interface gdw_chan_if #(
	parameter type T = logic
) ();
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

/* sv/gdw_sram.sv */
`timescale 1ns / 1ps

// one write port, one read port, registered read data
module gdw_sram #(
	parameter int WIDTH = 2,
	parameter int AW    = 8
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [0:(1 << AW)-1];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

/* sv/gdw_cfg_regs.sv */
`timescale 1ns / 1ps

// grid size registers, clamped to the usable range
module gdw_cfg_regs #(
	parameter int MAX_ROWS = gdw_pkg::MAX_ROWS_DEF,
	parameter int MAX_COLS = gdw_pkg::MAX_COLS_DEF,
	parameter int ERW      = 5,
	parameter int ECW      = 5
) (
	input  logic           clk,
	input  logic           arst_n,
	gdw_chan_if.sink       wr,
	output logic [ERW-1:0] eff_rows,
	output logic [ECW-1:0] eff_cols,
	output logic           upd
);

	logic [gdw_pkg::CFG_W-1:0] rows_q;
	logic [gdw_pkg::CFG_W-1:0] cols_q;
	logic                      wr_fire;

	assign wr.ready = 1'b1;
	assign wr_fire  = wr.valid;
	assign upd      = wr_fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= gdw_pkg::CFG_RESET;
			cols_q <= gdw_pkg::CFG_RESET;
		end else if (wr_fire) begin
			case (wr.data.index)
				gdw_pkg::REG_ROWS: rows_q <= wr.data.value;
				gdw_pkg::REG_COLS: cols_q <= wr.data.value;
				default: ;
			endcase
		end
	end

	// zero counts as one, anything above the maximum as the maximum
	always_comb begin
		if (rows_q == '0) begin
			eff_rows = ERW'(1);
		end else if (32'(rows_q) > MAX_ROWS) begin
			eff_rows = ERW'(MAX_ROWS);
		end else begin
			eff_rows = ERW'(rows_q);
		end
		if (cols_q == '0) begin
			eff_cols = ECW'(1);
		end else if (32'(cols_q) > MAX_COLS) begin
			eff_cols = ECW'(MAX_COLS);
		end else begin
			eff_cols = ECW'(cols_q);
		end
	end

endmodule

/* sv/grid_dfs_component_walker.sv */
`timescale 1ns / 1ps

// Depth-first walker over a grid of open/closed cells, 4-neighbour moves.
// Channels: item (sink) takes load words (opcode 0: store one cell) and
// advance words (opcode 1: return the next visited cell); result (source)
// gives one word per advance; cfg (sink) writes rows_in_use (index 0) and
// cols_in_use (index 1) and is always ready.
// One item is worked on at a time; item.ready is high only while idle.
// A load is written to the grid memory in the cycle it is taken. An
// advance right after reset, a load or a cfg write first sweeps the grid
// memory to clear the visited marks. The walk then tries each neighbour
// inside the grid, skips each neighbour off its edge, pops the stack and
// scans cells for a new start, then hands the word to the output
// register; all limited by the single read port of the grid memory.
// Reset runs a clearing pass over the grid memory, during which no item
// is taken (cfg writes still are).
// A stalled result holds in the output register; the next result waits in
// the block until the register is free, and no item is taken meanwhile.
module grid_dfs_component_walker #(
	parameter int MAX_ROWS = gdw_pkg::MAX_ROWS_DEF,
	parameter int MAX_COLS = gdw_pkg::MAX_COLS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	gdw_chan_if.sink   item,
	gdw_chan_if.source result,
	gdw_chan_if.sink   cfg
);

	localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int CW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int AW    = RW + CW;
	localparam int ERW   = RW + 1;
	localparam int ECW   = CW + 1;
	localparam int SPW   = AW + 1;
	localparam int CELLS = MAX_ROWS * MAX_COLS;
	localparam int DW    = gdw_pkg::DIR_W;
	localparam int SEW   = RW + CW + DW;
	localparam int GW    = gdw_pkg::GRID_W;

	localparam logic [2:0] ST_INIT     = 3'd0;
	localparam logic [2:0] ST_IDLE     = 3'd1;
	localparam logic [2:0] ST_SWEEP    = 3'd2;
	localparam logic [2:0] ST_STEP     = 3'd3;
	localparam logic [2:0] ST_NB_CHK   = 3'd4;
	localparam logic [2:0] ST_SCAN_CHK = 3'd5;
	localparam logic [2:0] ST_POP_WAIT = 3'd6;
	localparam logic [2:0] ST_EMIT     = 3'd7;

	logic [2:0]            state_q;
	logic [SPW-1:0]        cnt_q;
	logic [SPW-1:0]        sp_q;
	logic [RW-1:0]         top_r_q;
	logic [CW-1:0]         top_c_q;
	logic [DW-1:0]         top_d_q;
	logic [RW-1:0]         cand_r_q;
	logic [CW-1:0]         cand_c_q;
	logic [ERW-1:0]        scan_r_q;
	logic [CW-1:0]         scan_c_q;
	logic                  restart_q;
	logic                  swp_pend_s1;
	logic [AW-1:0]         swp_addr_s1;
	gdw_pkg::result_t      res_q;
	gdw_pkg::result_t      out_q;
	logic                  out_valid_q;

	logic [ERW-1:0]        eff_rows;
	logic [ECW-1:0]        eff_cols;
	logic                  cfg_upd;

	logic                  item_fire;
	logic                  load_in_range;
	logic                  nb_ok;
	logic [RW-1:0]         nb_r;
	logic [CW-1:0]         nb_c;
	logic                  scan_last_c;
	logic                  cand_free;

	logic                  g_we;
	logic [AW-1:0]         g_waddr;
	logic [GW-1:0]         g_wdata;
	logic [AW-1:0]         g_raddr;
	logic [GW-1:0]         g_rdata;

	logic                  s_we;
	logic [AW-1:0]         s_waddr;
	logic [SEW-1:0]        s_wdata;
	logic [AW-1:0]         s_raddr;
	logic [SEW-1:0]        s_rdata;

	gdw_cfg_regs #(
		.MAX_ROWS (MAX_ROWS),
		.MAX_COLS (MAX_COLS),
		.ERW      (ERW),
		.ECW      (ECW)
	) u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr       (cfg),
		.eff_rows (eff_rows),
		.eff_cols (eff_cols),
		.upd      (cfg_upd)
	);

	// open and visited bit per cell
	gdw_sram #(
		.WIDTH (GW),
		.AW    (AW)
	) u_grid (
		.clk   (clk),
		.we    (g_we),
		.waddr (g_waddr),
		.wdata (g_wdata),
		.raddr (g_raddr),
		.rdata (g_rdata)
	);

	// walk stack below the cached top entry
	gdw_sram #(
		.WIDTH (SEW),
		.AW    (AW)
	) u_stack (
		.clk   (clk),
		.we    (s_we),
		.waddr (s_waddr),
		.wdata (s_wdata),
		.raddr (s_raddr),
		.rdata (s_rdata)
	);

	assign item.ready   = (state_q == ST_IDLE);
	assign item_fire    = item.valid && (state_q == ST_IDLE);
	assign result.valid = out_valid_q;
	assign result.data  = out_q;

	assign load_in_range = (32'(item.data.cell_row) < MAX_ROWS) &&
		(32'(item.data.cell_col) < MAX_COLS);
	assign scan_last_c = (({1'b0, scan_c_q} + ECW'(1)) == eff_cols);
	assign cand_free   = g_rdata[gdw_pkg::GRID_OPEN] && !g_rdata[gdw_pkg::GRID_VISIT];

	// neighbour of the top entry in its current direction
	always_comb begin
		nb_ok = 1'b0;
		nb_r  = top_r_q;
		nb_c  = top_c_q;
		case (top_d_q)
			gdw_pkg::DIR_UP: begin
				nb_ok = (top_r_q != '0);
				nb_r  = top_r_q - RW'(1);
			end
			gdw_pkg::DIR_DOWN: begin
				nb_ok = (({1'b0, top_r_q} + ERW'(1)) < eff_rows);
				nb_r  = top_r_q + RW'(1);
			end
			gdw_pkg::DIR_LEFT: begin
				nb_ok = (top_c_q != '0);
				nb_c  = top_c_q - CW'(1);
			end
			gdw_pkg::DIR_RIGHT: begin
				nb_ok = (({1'b0, top_c_q} + ECW'(1)) < eff_cols);
				nb_c  = top_c_q + CW'(1);
			end
			default: nb_ok = 1'b0;
		endcase
	end

	// grid memory ports
	always_comb begin
		g_we    = 1'b0;
		g_waddr = '0;
		g_wdata = '0;
		if (state_q == ST_INIT) begin
			g_we    = !cnt_q[AW];
			g_waddr = AW'(cnt_q);
		end else if (swp_pend_s1) begin
			g_we    = 1'b1;
			g_waddr = swp_addr_s1;
			g_wdata[gdw_pkg::GRID_OPEN] = g_rdata[gdw_pkg::GRID_OPEN];
		end else if (item_fire && item.data.opcode == gdw_pkg::OP_LOAD) begin
			g_we    = load_in_range;
			g_waddr = {RW'(item.data.cell_row), CW'(item.data.cell_col)};
			g_wdata[gdw_pkg::GRID_OPEN] = item.data.cell_open;
		end else if ((state_q == ST_NB_CHK || state_q == ST_SCAN_CHK) && cand_free) begin
			g_we    = 1'b1;
			g_waddr = {cand_r_q, cand_c_q};
			g_wdata = '1;
		end

		case (state_q)
			ST_SWEEP: g_raddr = AW'(cnt_q);
			ST_STEP:  g_raddr = (sp_q != '0) ? {nb_r, nb_c} : {RW'(scan_r_q), scan_c_q};
			default:  g_raddr = '0;
		endcase
	end

	// stack memory ports: push the old top, refill the top on a pop
	always_comb begin
		s_we    = (state_q == ST_NB_CHK) && cand_free;
		s_waddr = AW'(sp_q - SPW'(1));
		s_wdata = {top_r_q, top_c_q, top_d_q};
		s_raddr = AW'(sp_q - SPW'(2));
	end

	// walk sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			cnt_q       <= '0;
			sp_q        <= '0;
			scan_r_q    <= '0;
			scan_c_q    <= '0;
			restart_q   <= 1'b1;
			swp_pend_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			swp_pend_s1 <= 1'b0;
			if (cfg_upd) begin
				restart_q <= 1'b1;
			end
			if (result.ready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_INIT: begin
					if (cnt_q[AW]) begin
						state_q <= ST_IDLE;
					end else begin
						cnt_q <= cnt_q + SPW'(1);
					end
				end

				ST_IDLE: begin
					if (item_fire) begin
						if (item.data.opcode == gdw_pkg::OP_LOAD) begin
							restart_q <= 1'b1;
						end else if (restart_q) begin
							cnt_q     <= '0;
							sp_q      <= '0;
							scan_r_q  <= '0;
							scan_c_q  <= '0;
							restart_q <= 1'b0;
							state_q   <= ST_SWEEP;
						end else begin
							state_q <= ST_STEP;
						end
					end
				end

				// read each entry, write it back next cycle with visited cleared
				ST_SWEEP: begin
					if (cnt_q[AW]) begin
						state_q <= ST_STEP;
					end else begin
						swp_pend_s1 <= 1'b1;
						swp_addr_s1 <= AW'(cnt_q);
						cnt_q       <= cnt_q + SPW'(1);
					end
				end

				ST_STEP: begin
					if (sp_q != '0) begin
						if (top_d_q == gdw_pkg::DIR_END) begin
							sp_q <= sp_q - SPW'(1);
							if (sp_q >= SPW'(2)) begin
								state_q <= ST_POP_WAIT;
							end
						end else begin
							top_d_q  <= top_d_q + DW'(1);
							cand_r_q <= nb_r;
							cand_c_q <= nb_c;
							if (nb_ok) begin
								state_q <= ST_NB_CHK;
							end
						end
					end else if (scan_r_q < eff_rows) begin
						cand_r_q <= RW'(scan_r_q);
						cand_c_q <= scan_c_q;
						if (scan_last_c) begin
							scan_c_q <= '0;
							scan_r_q <= scan_r_q + ERW'(1);
						end else begin
							scan_c_q <= scan_c_q + CW'(1);
						end
						state_q <= ST_SCAN_CHK;
					end else begin
						res_q.out_row  <= '0;
						res_q.out_col  <= '0;
						res_q.new_path <= 1'b0;
						res_q.done_res <= 1'b1;
						state_q        <= ST_EMIT;
					end
				end

				ST_NB_CHK, ST_SCAN_CHK: begin
					if (cand_free) begin
						top_r_q        <= cand_r_q;
						top_c_q        <= cand_c_q;
						top_d_q        <= gdw_pkg::DIR_UP;
						sp_q           <= sp_q + SPW'(1);
						res_q.out_row  <= gdw_pkg::COORD_W'(cand_r_q);
						res_q.out_col  <= gdw_pkg::COORD_W'(cand_c_q);
						res_q.new_path <= (state_q == ST_SCAN_CHK);
						res_q.done_res <= 1'b0;
						state_q        <= ST_EMIT;
					end else begin
						state_q <= ST_STEP;
					end
				end

				ST_POP_WAIT: begin
					{top_r_q, top_c_q, top_d_q} <= s_rdata;
					state_q <= ST_STEP;
				end

				ST_EMIT: begin
					if (!out_valid_q || result.ready) begin
						out_q       <= res_q;
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end

				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// stack never holds more cells than the grid has
	a_sp_bound: assert property (@(posedge clk) disable iff (!arst_n)
		sp_q <= SPW'(CELLS))
		else $error("walk stack deeper than grid");

	// a done word carries zero coordinates and no new-path flag
	a_done_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.done_res) |->
		(out_q.out_row == '0 && out_q.out_col == '0 && !out_q.new_path))
		else $error("done word with payload");

	// a new component starts from an otherwise empty stack
	a_new_path_depth: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT && res_q.new_path) |-> (sp_q == SPW'(1)))
		else $error("new path with stale stack");

	// a load always schedules a restart of the walk
	a_load_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(item_fire && item.data.opcode == gdw_pkg::OP_LOAD) |=> restart_q)
		else $error("load without restart");

endmodule
